FILE: hdl/receiver_bind_pulse_sequencer_macros.svh
// Assertion macros used by the checker file of the bind sequencer.
`ifndef RECEIVER_BIND_PULSE_SEQUENCER_MACROS_SVH
`define RECEIVER_BIND_PULSE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbps_pkg;

  // Sequence phases as shown on the result channel.
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_POWER_OFF = 3'd1;
  localparam logic [2:0] PH_SETTLE    = 3'd2;
  localparam logic [2:0] PH_PULSING   = 3'd3;
  localparam logic [2:0] PH_RELEASE   = 3'd4;

  // Position inside the pulse train.
  localparam logic [1:0] HP_LEAD  = 2'd0;
  localparam logic [1:0] HP_ARMED = 2'd1;
  localparam logic [1:0] HP_LOW   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_POWER_OFF_MS = 2'd0;
  localparam logic [1:0] REG_SETTLE_MS    = 2'd1;
  localparam logic [1:0] REG_RELEASE_MS   = 2'd2;
  localparam logic [1:0] REG_PULSE_COUNT  = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] POWER_OFF_MS_RST = 16'd500;
  localparam logic [15:0] SETTLE_MS_RST    = 16'd72;
  localparam logic [15:0] RELEASE_MS_RST   = 16'd50;
  localparam logic [3:0]  PULSE_COUNT_RST  = 4'd9;

  typedef struct packed {
    logic start_bind;
    logic ms_elapsed;
  } in_item_t;

  typedef struct packed {
    logic       power_enable;
    logic       signal_level;
    logic       signal_driven;
    logic [2:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [15:0] power_off_ms;
    logic [15:0] settle_ms;
    logic [15:0] release_ms;
    logic [3:0]  pulse_count;
  } cfg_regs_t;

endpackage

`default_nettype wire

FILE: hdl/rbps_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rbps_seq
  import rbps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire in_item_t  item,
  input  wire cfg_regs_t cfg,
  output out_item_t      result_nxt
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [2:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [3:0]             pulses_r, pulses_nxt, pulses_inc;
  logic [1:0]             half_r, half_nxt;
  logic                   power_r, power_nxt;
  logic                   level_r, level_nxt;
  logic                   drive_r, drive_nxt;
  logic [15:0]            limit;
  logic                   wait_hit;

  // Saturating tick count and the end-of-wait compare for the current phase.
  always_comb begin
    elapsed_inc = elapsed_r;
    if (item.ms_elapsed && (elapsed_r != CNT_MAX)) begin
      elapsed_inc = elapsed_r + 1'b1;
    end
    case (phase_r)
      PH_POWER_OFF: limit = cfg.power_off_ms;
      PH_SETTLE:    limit = cfg.settle_ms;
      default:      limit = cfg.release_ms;
    endcase
    // A limit above the counter range is reached once the counter is full.
    wait_hit = (CMP_W'(elapsed_inc) >= CMP_W'(limit)) || (elapsed_inc == CNT_MAX);
  end

  assign pulses_inc = pulses_r + 4'd1;

  // Next state for one accepted item.
  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    pulses_nxt  = pulses_r;
    half_nxt    = half_r;
    power_nxt   = power_r;
    level_nxt   = level_r;
    drive_nxt   = drive_r;
    if (item.start_bind) begin
      phase_nxt   = PH_POWER_OFF;
      power_nxt   = 1'b0;
      level_nxt   = 1'b1;
      drive_nxt   = 1'b1;
      elapsed_nxt = '0;
      pulses_nxt  = '0;
      half_nxt    = HP_LEAD;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_POWER_OFF: begin
          elapsed_nxt = elapsed_inc;
          if (wait_hit) begin
            power_nxt   = 1'b1;
            phase_nxt   = PH_SETTLE;
            elapsed_nxt = '0;
          end
        end
        PH_SETTLE: begin
          elapsed_nxt = elapsed_inc;
          if (wait_hit) begin
            phase_nxt   = PH_PULSING;
            half_nxt    = HP_LEAD;
            pulses_nxt  = '0;
            elapsed_nxt = '0;
          end
        end
        PH_PULSING: begin
          if (item.ms_elapsed) begin
            case (half_r)
              HP_ARMED: begin
                level_nxt = 1'b0;
                half_nxt  = HP_LOW;
              end
              HP_LOW: begin
                level_nxt  = 1'b1;
                pulses_nxt = pulses_inc;
                // A zero count ends the train after one pulse; a wrapped pulse counter also ends it.
                if ((pulses_inc >= cfg.pulse_count) || (pulses_inc == 4'd0)) begin
                  phase_nxt   = PH_RELEASE;
                  elapsed_nxt = '0;
                  half_nxt    = HP_LEAD;
                end else begin
                  half_nxt = HP_ARMED;
                end
              end
              default: half_nxt = HP_ARMED;
            endcase
          end
        end
        PH_RELEASE: begin
          elapsed_nxt = elapsed_inc;
          if (wait_hit) begin
            drive_nxt = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      pulses_r  <= '0;
      half_r    <= HP_LEAD;
      power_r   <= 1'b1;
      level_r   <= 1'b1;
      drive_r   <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      pulses_r  <= pulses_nxt;
      half_r    <= half_nxt;
      power_r   <= power_nxt;
      level_r   <= level_nxt;
      drive_r   <= drive_nxt;
    end
  end

  // The result shows the state after the item.
  assign result_nxt.power_enable  = power_nxt;
  assign result_nxt.signal_level  = level_nxt;
  assign result_nxt.signal_driven = drive_nxt;
  assign result_nxt.phase         = phase_nxt;

endmodule

`default_nettype wire

FILE: hdl/receiver_bind_pulse_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Bind-mode sequencer for a satellite radio receiver.
// Input channel (in_valid/in_ready/in_data): one item per millisecond tick or
// request, carrying start_bind and ms_elapsed. Result channel
// (out_valid/out_ready/out_data): one result per item with power enable,
// signal line level, drive enable and the current phase.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 power-off time, 1 settle time, 2 release time, 3 pulse count).
// The result of an item is valid in the cycle after its transfer. The block
// takes one item per cycle while results are taken; the state update and the
// result register sit in a single stage behind the input transfer.
// While a result waits on out_ready low, the stage is full and in_ready
// drops; it rises again in the cycle the result transfers.
// Reset (rst_n low, synchronous) empties the result register, puts the
// sequencer idle with power on, the line released and level high, and
// loads the default register values (500, 72, 50, 9).

module receiver_bind_pulse_sequencer
  import rbps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  cfg_regs_t cfg_r;
  out_item_t out_data_r;
  out_item_t result_nxt;
  logic      out_valid_r;
  logic      in_xfer;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_off_ms <= POWER_OFF_MS_RST;
      cfg_r.settle_ms    <= SETTLE_MS_RST;
      cfg_r.release_ms   <= RELEASE_MS_RST;
      cfg_r.pulse_count  <= PULSE_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_POWER_OFF_MS: cfg_r.power_off_ms <= cfg_wdata;
        REG_SETTLE_MS:    cfg_r.settle_ms    <= cfg_wdata;
        REG_RELEASE_MS:   cfg_r.release_ms   <= cfg_wdata;
        REG_PULSE_COUNT:  cfg_r.pulse_count  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // The stage takes a new item when empty or when its result leaves now.
  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  rbps_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_xfer),
    .item      (in_data),
    .cfg       (cfg_r),
    .result_nxt(result_nxt)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/rbps_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "receiver_bind_pulse_sequencer_macros.svh"

module rbps_chk
  import rbps_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result keeps its value.
  `RBPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // An empty result stage always takes input.
  `RBPS_ASSERT_NOW(a_ready_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty stage")

  // Every input transfer produces a result in the next cycle.
  `RBPS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "no result after input transfer")

  // The line is driven exactly while a sequence runs.
  `RBPS_ASSERT_NOW(a_drive_phase, clk, rst_n, out_valid, (out_data.phase == PH_IDLE) == !out_data.signal_driven, "drive enable does not match phase")

  // Power is off exactly in the power-off phase.
  `RBPS_ASSERT_NOW(a_power_phase, clk, rst_n, out_valid, (out_data.phase == PH_POWER_OFF) == !out_data.power_enable, "power does not match phase")

endmodule

bind receiver_bind_pulse_sequencer rbps_chk u_rbps_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire

FILE: tb/receiver_bind_pulse_sequencer_tb.sv
`timescale 1ns / 1ps

module receiver_bind_pulse_sequencer_tb;
  import rbps_pkg::*;

  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam int QUIET_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = REG_POWER_OFF_MS;
  logic [15:0] cfg_wdata = '0;

  receiver_bind_pulse_sequencer #(.COUNT_WIDTH(CNT_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Free-running 20 ns clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow copy of the sequencer state and its registers.
  logic [2:0]       seq_phase;
  logic [CNT_W-1:0] tick_count;
  logic [3:0]       pulses_sent;
  logic [1:0]       half_slot;
  logic             power_on;
  logic             line_level;
  logic             line_driven;
  logic [15:0]      power_off_time;
  logic [15:0]      settle_time;
  logic [15:0]      release_time;
  logic [3:0]       pulse_target;

  in_item_t  pending_items[$];
  out_item_t expected_outputs[$];
  out_item_t oldest_expected;

  int  mismatches = 0;
  int  items_accepted = 0;
  int  sequences_completed = 0;
  int  settings_loaded = 0;
  int  quiet_cycles = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  logic idle_on = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Tick counting for the waiting phases; the count saturates at the top.
  function automatic logic count_reached(input logic tick, input logic [15:0] limit);
    logic [CNT_W-1:0] thr;
    thr = (limit > CNT_TOP) ? CNT_TOP : CNT_W'(limit);
    if (tick && tick_count < CNT_TOP) tick_count = tick_count + 1'b1;
    return tick_count >= thr;
  endfunction

  // Advance the shadow sequencer by one item and return the levels it shows.
  function automatic out_item_t step_bind_sequencer(input in_item_t it);
    out_item_t res;
    if (it.start_bind) begin
      seq_phase   = PH_POWER_OFF;
      power_on    = 1'b0;
      line_level  = 1'b1;
      line_driven = 1'b1;
      tick_count  = '0;
      pulses_sent = '0;
      half_slot   = HP_LEAD;
    end else begin
      case (seq_phase)
        PH_IDLE: begin
        end
        PH_POWER_OFF: begin
          if (count_reached(it.ms_elapsed, power_off_time)) begin
            power_on   = 1'b1;
            seq_phase  = PH_SETTLE;
            tick_count = '0;
          end
        end
        PH_SETTLE: begin
          if (count_reached(it.ms_elapsed, settle_time)) begin
            seq_phase   = PH_PULSING;
            half_slot   = HP_LEAD;
            pulses_sent = '0;
            tick_count  = '0;
          end
        end
        PH_PULSING: begin
          if (it.ms_elapsed) begin
            if (half_slot == HP_ARMED) begin
              line_level = 1'b0;
              half_slot  = HP_LOW;
            end else if (half_slot == HP_LOW) begin
              // End of a low pulse; a zero target still sends one pulse.
              line_level  = 1'b1;
              pulses_sent = pulses_sent + 1'b1;
              if (pulses_sent >= pulse_target || pulses_sent == 4'd0) begin
                seq_phase  = PH_RELEASE;
                tick_count = '0;
                half_slot  = HP_LEAD;
              end else begin
                half_slot = HP_ARMED;
              end
            end else begin
              half_slot = HP_ARMED;
            end
          end
        end
        PH_RELEASE: begin
          if (count_reached(it.ms_elapsed, release_time)) begin
            line_driven = 1'b0;
            seq_phase   = PH_IDLE;
            sequences_completed++;
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    end
    res.power_enable  = power_on;
    res.signal_level  = line_level;
    res.signal_driven = line_driven;
    res.phase         = seq_phase;
    return res;
  endfunction

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: presents queued items and holds each until its transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
        in_gap   <= idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idle_on) out_stall <= pick_gap();
    end
  end

  // Monitor: tracks register writes, predicts on each input transfer and
  // checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase      = PH_IDLE;
      tick_count     = '0;
      pulses_sent    = '0;
      half_slot      = HP_LEAD;
      power_on       = 1'b1;
      line_level     = 1'b1;
      line_driven    = 1'b0;
      power_off_time = POWER_OFF_MS_RST;
      settle_time    = SETTLE_MS_RST;
      release_time   = RELEASE_MS_RST;
      pulse_target   = PULSE_COUNT_RST;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_POWER_OFF_MS: power_off_time = cfg_wdata;
          REG_SETTLE_MS:    settle_time    = cfg_wdata;
          REG_RELEASE_MS:   release_time   = cfg_wdata;
          REG_PULSE_COUNT:  pulse_target   = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_outputs.push_back(step_bind_sequencer(in_data));
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          report_mismatch("result with nothing pending", out_data, 0);
        end else begin
          oldest_expected = expected_outputs.pop_front();
          if (out_data.power_enable !== oldest_expected.power_enable)
            report_mismatch("power_enable", out_data.power_enable,
                            oldest_expected.power_enable);
          if (out_data.signal_level !== oldest_expected.signal_level)
            report_mismatch("signal_level", out_data.signal_level,
                            oldest_expected.signal_level);
          if (out_data.signal_driven !== oldest_expected.signal_driven)
            report_mismatch("signal_driven", out_data.signal_driven,
                            oldest_expected.signal_driven);
          if (out_data.phase !== oldest_expected.phase)
            report_mismatch("phase", out_data.phase, oldest_expected.phase);
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("receiver_bind_pulse_sequencer_tb: done, errors");
      $finish;
    end
  end

  task automatic add_item(input logic start, input logic tick);
    in_item_t it;
    it.start_bind = start;
    it.ms_elapsed = tick;
    pending_items.push_back(it);
  endtask

  // Wait until every queued item has gone through and every result arrived.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles.
  task automatic load_settings(input logic [15:0] p, input logic [15:0] s,
                               input logic [15:0] r, input logic [3:0] c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_POWER_OFF_MS;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_addr  <= REG_SETTLE_MS;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_addr  <= REG_RELEASE_MS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr  <= REG_PULSE_COUNT;
    cfg_wdata <= {12'd0, c};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  // Mostly complete bind sequences with random tick spacing, some cut short,
  // mixed with bursts of arbitrary items. The budget caps the item count.
  task automatic add_random_traffic(input int budget, input logic [15:0] p,
                                    input logic [15:0] s, input logic [15:0] r,
                                    input logic [3:0] c);
    int added, len, k, pc, pw, sw, rw;
    added = 0;
    pc = (c == 4'd0) ? 1 : int'(c);
    pw = (p > 16'd40) ? 40 : int'(p);
    sw = (s > 16'd40) ? 40 : int'(s);
    rw = (r > 16'd40) ? 40 : int'(r);
    while (added < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, 6);
        if (len > budget - added) len = budget - added;
        for (k = 0; k < len; k++)
          add_item($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
      end else begin
        len = (pw + sw + rw + 2 + 2 * pc) * 4 / 3 + 4;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        if (len > budget - added) len = budget - added;
        add_item(1'b1, 1'($urandom_range(0, 1)));
        for (k = 1; k < len; k++)
          add_item($urandom_range(0, 999) < 3, $urandom_range(0, 99) < 75);
      end
      added += len;
    end
  endtask

  function automatic logic [15:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(8, 25));
    return 16'($urandom_range(1, 5));
  endfunction

  // Stimulus sequence.
  initial begin
    logic [15:0] p, s, r;
    logic [3:0]  c;
    int ph;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Default registers: idle ticks, start together with a tick, restart.
    add_item(1'b0, 1'b0);
    add_item(1'b0, 1'b1);
    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b0);
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b1);
    drain();

    // Shortest nonzero times: one full sequence with a single pulse.
    load_settings(16'd1, 16'd1, 16'd1, 4'd1);
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b0);
    for (ph = 0; ph < 6; ph++) add_item(1'b0, 1'b1);
    drain();

    // Zero times end each wait at once; a zero pulse count sends one pulse.
    load_settings(16'd0, 16'd0, 16'd0, 4'd0);
    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b0);
    add_item(1'b0, 1'b0);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b1);
    add_item(1'b0, 1'b0);
    drain();

    // Largest register values: the sequence only gets into power off.
    idle_on = 1'b1;
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    add_random_traffic(60, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
    drain();

    // Random settings with short times, some phases without idling.
    for (ph = 0; ph < 13; ph++) begin
      p = pick_time();
      s = pick_time();
      r = pick_time();
      c = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom_range(0, 15));
      idle_on = (ph % 3 != 1);
      load_settings(p, s, r, c);
      add_random_traffic(130, p, s, r, c);
      drain();
    end

    $display("Covered %0d items across %0d register settings after the defaults.",
             items_accepted, settings_loaded);
    $display("%0d bind sequences ran through release back to idle.",
             sequences_completed);
    if (mismatches == 0) begin
      $display("receiver_bind_pulse_sequencer_tb: done, clean");
    end else begin
      $display("receiver_bind_pulse_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: receiver_bind_pulse_sequencer.f
+incdir+hdl
hdl/rbps_pkg.sv
hdl/rbps_seq.sv
hdl/receiver_bind_pulse_sequencer.sv
hdl/rbps_chk.sv
tb/receiver_bind_pulse_sequencer_tb.sv
